// ----- src/f64ms_pkg.sv -----
package f64ms_pkg;

  localparam int unsigned WordW = 64;
  localparam int unsigned MantW = 52;
  localparam int unsigned ExpW  = 11;
  localparam logic [WordW-1:0] SignMask = 64'h8000000000000000;
  localparam logic [WordW-1:0] MantMask = 64'h000FFFFFFFFFFFFF;
  localparam logic [WordW-1:0] QuietBit = 64'h0008000000000000;
  localparam logic [ExpW-1:0]  ExpAllOnes = 11'h7FF;
  localparam logic [ExpW-1:0]  ExpBias = 11'd1023;

  typedef struct packed {
    logic [WordW-1:0] fraction_bits;
    logic [WordW-1:0] integer_bits;
  } split_t;

endpackage

// ----- src/f64ms_core.sv -----
module f64ms_core (
  input  logic [63:0]           value_bits,
  output f64ms_pkg::split_t     result
);
  import f64ms_pkg::*;

  logic [WordW-1:0] sign;
  logic [ExpW-1:0]  bexp;
  logic [MantW:0]   m;
  logic [5:0]       e;
  logic [5:0]       shift;
  logic [MantW:0]   low_mask;
  logic [MantW:0]   f;
  logic [5:0]       p;
  logic [MantW:0]   fn;
  logic [ExpW-1:0]  fexp;

  always_comb begin
    sign = value_bits & SignMask;
    bexp = value_bits[62:52];
    m = {1'b1, value_bits[MantW-1:0]};
    e = bexp[5:0] - ExpBias[5:0];
    shift = 6'(MantW) - e;
    low_mask = (53'd1 << shift) - 53'd1;
    f = m & low_mask;
    p = '0;
    for (int i = 0; i < MantW + 1; i++) begin
      if (f[i]) p = 6'(i);
    end
    fn = f << (6'(MantW) - p);
    fexp = ExpBias - 11'(shift) + 11'(p);
    result.integer_bits = value_bits & ~{11'd0, low_mask};
    result.fraction_bits = (f == '0) ? sign : (sign | {1'b0, fexp, fn[MantW-1:0]});
    if (bexp == ExpAllOnes) begin
      result.integer_bits = value_bits;
      result.fraction_bits = (value_bits[MantW-1:0] != '0) ? (value_bits | QuietBit) : sign;
    end else if (bexp < ExpBias) begin
      result.integer_bits = sign;
      result.fraction_bits = value_bits;
    end else if (bexp >= ExpBias + 11'(MantW)) begin
      result.integer_bits = value_bits;
      result.fraction_bits = sign;
    end
  end
endmodule

// ----- src/float64_modf_split.sv -----
// channel | direction | tdata fields (low bit up)
// in_     | slave     | value_bits[63:0]
// out_    | master    | fraction_bits[63:0], integer_bits[127:64]
// one beat per cycle while out_tready is high; a beat passes through the input
// register and then sits in the result register
// rate set by the single pass of the split logic between the registers
// rst_n clears only the valid flags
// out_tready low holds the result; the input register still fills if empty
module float64_modf_split (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [63:0]  in_tdata,   // value_bits
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [127:0] out_tdata   // fraction_bits, integer_bits
);
  import f64ms_pkg::*;

  logic        a_vld_r, a_vld_nxt, b_vld_r, b_vld_nxt;
  logic [63:0] a_r;
  split_t      res, b_r;
  logic        b_load, a_load;

  // stage b takes a new beat when empty or draining
  assign b_load    = !b_vld_r || out_tready;
  assign in_tready = !a_vld_r || b_load;
  assign a_load    = in_tvalid && in_tready;

  f64ms_core u_core (.value_bits(a_r), .result(res));

  always_comb begin
    a_vld_nxt = a_load ? 1'b1 : (b_load ? 1'b0 : a_vld_r);
    b_vld_nxt = b_load ? a_vld_r : b_vld_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
      b_vld_r <= 1'b0;
    end else begin
      a_vld_r <= a_vld_nxt;
      b_vld_r <= b_vld_nxt;
    end
    if (a_load) a_r <= in_tdata;
    if (b_load && a_vld_r) b_r <= res;
  end

  assign out_tvalid = b_vld_r;
  assign out_tdata  = {b_r.integer_bits, b_r.fraction_bits};

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed under stall");
  a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input blocked with empty output");
  a_fill: assert property (@(posedge clk) disable iff (!rst_n)
    a_vld_r && (!b_vld_r || out_tready) |=> out_tvalid)
    else $error("beat lost between stages");
endmodule
